// ===== design/dcq_pkg.sv =====
// Shared types, codes and helper functions for the deduplicating command queue.
// Used by dcq_rec_store and dedup_command_queue_core; depends on nothing else.
package dcq_pkg;

  // Record and task buffer geometry.
  localparam int REC_W           = 128;
  localparam int TASK_BYTES      = 15;
  localparam int TASK_W          = 8 * TASK_BYTES;
  localparam int MAX_ARG_LEN     = 10;
  localparam int DEF_QUEUE_DEPTH = 16;

  // Request function codes.
  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  // Status codes returned with every result.
  typedef enum logic [2:0] {
    STAT_ADDED      = 3'd0,
    STAT_DUPLICATE  = 3'd1,
    STAT_BAD_LENGTH = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_DISPATCHED = 3'd4,
    STAT_RESET      = 3'd5
  } status_e;

  // Key that identifies a record for the duplicate check.
  typedef struct packed {
    logic [23:0] cmd;   // command bytes and argument length (bytes 1..3)
    logic [3:0]  len;   // argument length, already checked to be in range
    logic [15:0] crc;   // the two bytes that follow the arguments
  } dcq_key_t;

  // Task buffer built from one stored record.
  typedef struct packed {
    logic [3:0]        tlen;
    logic [TASK_W-1:0] data;
  } task_buf_t;

  // Picks the two CRC bytes that follow the arguments of a record.
  function automatic logic [15:0] crc_at(input logic [REC_W-1:0] rec, input logic [3:0] len);
    logic [REC_W-1:0] sh;
    sh = rec >> (8 * (int'(len) + 4));
    return sh[15:0];
  endfunction

  // Builds the task buffer: header and command bytes, a zero byte, the length
  // byte and the arguments; everything past the valid length stays zero.
  function automatic task_buf_t build_task(input logic [REC_W-1:0] rec);
    task_buf_t  t;
    logic [3:0] arg_len;
    logic [3:0] total;
    arg_len = (rec[31:24] > 8'(MAX_ARG_LEN)) ? 4'(MAX_ARG_LEN) : rec[27:24];
    total   = arg_len + 4'd4;
    t.data  = '0;
    t.data[23:0] = rec[23:0];
    for (int i = 3; i < TASK_BYTES - 1; i++) begin
      if (4'(i) < total) begin
        t.data[8*(i+1) +: 8] = rec[8*i +: 8];
      end
    end
    t.tlen = total + 4'd1;
    return t;
  endfunction

endpackage

// ===== design/dcq_rec_store.sv =====
// Record memory of the command queue: one write port, one registered read port,
// and the duplicate compare on the read data. Depends on dcq_pkg.
module dcq_rec_store
  import dcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [REC_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  dcq_key_t         key_i,
  output logic [REC_W-1:0] rd_data_o,
  output logic             match_o
);

  logic [REC_W-1:0] mem_q [QUEUE_DEPTH];
  logic [REC_W-1:0] rd_data_q;

  // Synchronous write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Synchronous read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // The stored record is a duplicate when command bytes, length and CRC agree.
  // Equal length bytes put both CRCs at the same offset.
  assign match_o = (rd_data_q[31:8] == key_i.cmd) &&
                   (crc_at(rd_data_q, key_i.len) == key_i.crc);

endmodule

// ===== design/dedup_command_queue_core.sv =====
// Command queue with duplicate rejection: top level with the request sequencer.
// Depends on dcq_pkg and dcq_rec_store.
//
// Usage:
//   The input channel takes one request per handshake (in_valid_i high while
//   in_stall_o is low). func_i selects adding the record in entry_hi_i and
//   entry_lo_i, or servicing the queue. Every request gives exactly one result
//   on the output channel, held in a register until out_valid_o is seen with
//   out_stall_i low.
//   An add scans the stored records in turn through the single read port of the
//   record memory, one entry per cycle, stops at the first match, and writes the
//   new record back when none matches. Records with a bad length or a full queue
//   are answered without a scan. A dispatch reads the entry at the read index and
//   clears it; a queue reset answers without touching the memory. One request is
//   in work at a time; the next is accepted in the cycle after the result is
//   loaded into the output stage, even while that result still waits for the
//   receiver.
//   When the receiver stalls, the result holds, and the sequencer waits with
//   the following result until the output stage is free.
//   Reset empties the queue (fill count and read index zero). The memory is not
//   cleared: entries are only read after they were written.
module dedup_command_queue_core
  import dcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Request channel.
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          func_i,
  input  logic [63:0]   entry_lo_i,
  input  logic [63:0]   entry_hi_i,
  // Result channel.
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [63:0]   task_lo_o,
  output logic [55:0]   task_hi_o,
  output logic [3:0]    task_len_o,
  output logic [CW-1:0] fill_count_o,
  output logic [CW-1:0] read_index_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP,
    ST_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     issue_q, issue_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [REC_W-1:0]  rec_q, rec_d;
  dcq_key_t          key_q, key_d;
  logic [TASK_W-1:0] tdata_q, tdata_d;
  logic [3:0]        tlen_q, tlen_d;

  status_e           out_status_q;
  logic [TASK_W-1:0] out_tdata_q;
  logic [3:0]        out_tlen_q;
  logic [CW-1:0]     out_count_q;
  logic [CW-1:0]     out_ptr_q;

  logic              load_out;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [REC_W-1:0]  wr_data;
  logic [REC_W-1:0]  rd_data;
  logic              match;
  logic              scan_done;
  logic [REC_W-1:0]  in_rec;
  task_buf_t         disp_buf;

  dcq_rec_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .key_i     (key_q),
    .rd_data_o (rd_data),
    .match_o   (match)
  );

  assign in_rec   = {entry_hi_i, entry_lo_i};
  assign disp_buf = build_task(rd_data);

  // Sequencer: decode the request, scan or dispatch, then hand off the result.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    issue_d   = issue_q;
    pend_d    = pend_q;
    status_d  = status_q;
    rec_d     = rec_q;
    key_d     = key_q;
    tdata_d   = tdata_q;
    tlen_d    = tlen_q;
    load_out  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = issue_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_q[AW-1:0];
    wr_data   = rec_q;
    scan_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rec_d     = in_rec;
          key_d.cmd = in_rec[31:8];
          key_d.len = in_rec[27:24];
          key_d.crc = crc_at(in_rec, in_rec[27:24]);
          tdata_d   = '0;
          tlen_d    = '0;
          issue_d   = '0;
          pend_d    = 1'b0;
          if (func_i == FUNC_SERVICE) begin
            if (ptr_q >= count_q) begin
              ptr_d    = '0;
              count_d  = '0;
              status_d = STAT_RESET;
              state_d  = ST_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ptr_q[AW-1:0];
              state_d = ST_DISP;
            end
          end else if (in_rec[31:24] > 8'(MAX_ARG_LEN)) begin
            status_d = STAT_BAD_LENGTH;
            state_d  = ST_RESP;
          end else if (count_q >= CW'(QUEUE_DEPTH)) begin
            status_d = STAT_FULL;
            state_d  = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // One read issued per cycle; the compare sees the entry read last cycle.
        rd_en  = (issue_q < count_q);
        pend_d = rd_en;
        if (rd_en) begin
          issue_d = issue_q + CW'(1);
        end
        if (pend_q && match) begin
          status_d = STAT_DUPLICATE;
          state_d  = ST_RESP;
        end else if (!rd_en) begin
          scan_done = 1'b1;
          wr_en     = 1'b1;
          count_d   = count_q + CW'(1);
          status_d  = STAT_ADDED;
          state_d   = ST_RESP;
        end
      end

      ST_DISP: begin
        // Emit the entry at the read index and clear it in the memory.
        tdata_d  = disp_buf.data;
        tlen_d   = disp_buf.tlen;
        wr_en    = 1'b1;
        wr_addr  = ptr_q[AW-1:0];
        wr_data  = '0;
        ptr_d    = ptr_q + CW'(1);
        status_d = STAT_DISPATCHED;
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  // Control state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload and the output stage; these need no reset.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rec_q    <= rec_d;
    key_q    <= key_d;
    tdata_q  <= tdata_d;
    tlen_q   <= tlen_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_tdata_q  <= tdata_q;
      out_tlen_q   <= tlen_q;
      out_count_q  <= count_q;
      out_ptr_q    <= ptr_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign task_lo_o    = out_tdata_q[63:0];
  assign task_hi_o    = out_tdata_q[TASK_W-1:64];
  assign task_len_o   = out_tlen_q;
  assign fill_count_o = out_count_q;
  assign read_index_o = out_ptr_q;

  // The fill count never passes the depth and the read index never passes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(QUEUE_DEPTH)) && (ptr_q <= count_q))
    else $error("queue counters out of range");

  // The single-port sequencing never reads and writes the memory together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en && rd_en))
    else $error("memory read and write in the same cycle");

  // A completed scan without a match stores exactly one more record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> (count_q == $past(count_q) + CW'(1)))
    else $error("add did not advance the fill count");

  // A dispatched result always carries at least the fixed task bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_DISPATCHED)) |-> (task_len_o >= 4'd5))
    else $error("dispatched task buffer too short");

  // A new result is loaded only into a free or draining output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a stalled output");

endmodule
